// ===== rtl/gfl_pkg.sv =====
// gfl_pkg: shared types, constants and helpers of the grid force lookup-add core.
// Depends on nothing; every rtl file imports it.
package gfl_pkg;

  localparam int unsigned DataW      = 32;     // Q16.16 word
  localparam int unsigned IdxOutW    = 15;     // linear cell index field
  localparam int unsigned StoreDepth = 32768;  // hard cap on table entries
  localparam int unsigned RegIdxW    = 3;

  typedef logic signed [DataW-1:0] q16_t;

  typedef enum logic [RegIdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_CPL_X       = 3'd3,
    REG_CPL_Y       = 3'd4,
    REG_CPL_Z       = 3'd5,
    REG_FORCE_SCALE = 3'd6
  } reg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_APPLY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_BELOW    = 2'd1,
    ST_ABOVE    = 2'd2,
    ST_NO_GROUP = 2'd3
  } status_e;

  typedef struct packed {
    op_e                operation;
    q16_t               pos_x;
    q16_t               pos_y;
    q16_t               pos_z;
    q16_t               force_x;
    q16_t               force_y;
    q16_t               force_z;
    logic               in_group;
    logic [IdxOutW-1:0] entry_index;
    q16_t               entry_fx;
    q16_t               entry_fy;
    q16_t               entry_fz;
  } in_beat_t;

  typedef struct packed {
    q16_t               new_force_x;
    q16_t               new_force_y;
    q16_t               new_force_z;
    logic [IdxOutW-1:0] cell_index;
    status_e            status;
  } out_beat_t;

  typedef struct packed {
    q16_t x;
    q16_t y;
    q16_t z;
  } vec_t;

  // Per-axis cell: sign and magnitude of the truncated scaled offset
  typedef struct packed {
    logic             neg;
    logic [DataW-1:0] mag;
  } cell_t;

  // Lookup verdict: status plus the linear cell (zero unless applied)
  typedef struct packed {
    status_e            status;
    logic [IdxOutW-1:0] slot;
  } lookup_t;

  function automatic int unsigned table_cells(input int unsigned gx, input int unsigned gy,
                                              input int unsigned gz);
    int unsigned all_cells;
    all_cells = gx * gy * gz;
    return (all_cells > StoreDepth) ? StoreDepth : all_cells;
  endfunction

endpackage

// ===== rtl/gfl_axis.sv =====
// gfl_axis: two-stage cell computation for one axis (offset, then scale by cells per length).
// Depends on gfl_pkg.
module gfl_axis (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  gfl_pkg::q16_t            pos_i,
  input  gfl_pkg::q16_t            origin_i,
  input  logic [gfl_pkg::DataW-1:0] cpl_i,
  output gfl_pkg::cell_t           cell_o
);
  import gfl_pkg::*;

  logic signed [DataW:0]  diff;
  logic signed [DataW:0]  diff_abs;
  logic [DataW-1:0]       mag_d;
  logic [DataW-1:0]       mag_q;
  logic                   neg_q;
  logic [2*DataW-1:0]     prod;
  cell_t                  cell_q;

  // Offset is exact in 33 bits; its magnitude always fits in 32
  always_comb begin
    diff     = (DataW+1)'(pos_i) - (DataW+1)'(origin_i);
    diff_abs = diff[DataW] ? -diff : diff;
    mag_d    = diff_abs[DataW-1:0];
    prod     = (2*DataW)'(mag_q) * (2*DataW)'(cpl_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q      <= diff[DataW];
      mag_q      <= mag_d;
      cell_q.neg <= neg_q;
      cell_q.mag <= prod[2*DataW-1:DataW];
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== rtl/gfl_index.sv =====
// gfl_index: two-stage linear index build (scale by row and plane size, then sum and classify).
// Depends on gfl_pkg.
module gfl_index #(
  parameter int unsigned GRID_X = 32,
  parameter int unsigned GRID_Y = 32,
  parameter int unsigned GRID_Z = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  gfl_pkg::cell_t   cell_x_i,
  input  gfl_pkg::cell_t   cell_y_i,
  input  gfl_pkg::cell_t   cell_z_i,
  input  logic             grp_i,
  output gfl_pkg::lookup_t lookup_o
);
  import gfl_pkg::*;

  localparam int unsigned PlaneCells = GRID_X * GRID_Y;
  localparam int unsigned TableSize  = table_cells(GRID_X, GRID_Y, GRID_Z);
  localparam int unsigned PlaneW     = $clog2(PlaneCells + 1);
  localparam int unsigned RowW       = $clog2(GRID_X + 1);
  localparam int unsigned ZW         = DataW + PlaneW;
  localparam int unsigned YW         = DataW + RowW;
  localparam int unsigned SumW       = ZW + 2;

  logic [ZW-1:0]          pz_q;
  logic [YW-1:0]          py_q;
  logic [DataW-1:0]       px_q;
  logic                   nz_q;
  logic                   ny_q;
  logic                   nx_q;
  logic signed [SumW-1:0] tz;
  logic signed [SumW-1:0] ty;
  logic signed [SumW-1:0] tx;
  logic signed [SumW-1:0] sum;
  lookup_t                lookup_d;
  lookup_t                lookup_q;

  // Stage 3: scale z by the plane size and y by the row size
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pz_q <= ZW'(cell_z_i.mag) * ZW'(PlaneCells);
      py_q <= YW'(cell_y_i.mag) * YW'(GRID_X);
      px_q <= cell_x_i.mag;
      nz_q <= cell_z_i.neg;
      ny_q <= cell_y_i.neg;
      nx_q <= cell_x_i.neg;
    end
  end

  // Stage 4: apply signs, sum, and range check
  always_comb begin
    tz  = $signed(SumW'(pz_q));
    ty  = $signed(SumW'(py_q));
    tx  = $signed(SumW'(px_q));
    if (nz_q) tz = -tz;
    if (ny_q) ty = -ty;
    if (nx_q) tx = -tx;
    sum = tz + ty + tx;

    lookup_d.slot = '0;
    priority if (!grp_i) begin
      lookup_d.status = ST_NO_GROUP;
    end else if (sum[SumW-1]) begin
      lookup_d.status = ST_BELOW;
    end else if (sum >= $signed(SumW'(TableSize))) begin
      lookup_d.status = ST_ABOVE;
    end else begin
      lookup_d.status = ST_APPLIED;
      lookup_d.slot   = sum[IdxOutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lookup_q <= lookup_d;
    end
  end

  assign lookup_o = lookup_q;

endmodule

// ===== rtl/gfl_table.sv =====
// gfl_table: single-port force table; registered read per enable, write on load.
// Depends on gfl_pkg.
module gfl_table #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        load_i,
  input  logic [gfl_pkg::IdxOutW-1:0] addr_i,
  input  gfl_pkg::vec_t               wdata_i,
  output gfl_pkg::vec_t               rdata_o
);
  import gfl_pkg::*;

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vec_t       mem [DEPTH];
  vec_t       rdata_q;
  logic       hit;
  logic [AddrW-1:0] addr;

  // Drop loads that fall beyond the table
  assign hit  = {1'b0, addr_i} < (IdxOutW+1)'(DEPTH);
  assign addr = addr_i[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (load_i && hit) begin
        mem[addr] <= wdata_i;
      end
      rdata_q <= mem[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gfl_scale_add.sv =====
// gfl_scale_add: three-stage scaled add for one axis (multiply, round, saturating add).
// Depends on gfl_pkg.
module gfl_scale_add (
  input  logic          clk_i,
  input  logic          en_i,
  input  gfl_pkg::q16_t scale_i,
  input  gfl_pkg::q16_t entry_i,
  input  gfl_pkg::q16_t force_i,
  input  logic          use_i,
  output gfl_pkg::q16_t sum_o
);
  import gfl_pkg::*;

  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned FracW = DataW / 2;
  localparam int unsigned RndW  = ProdW - FracW;
  localparam int unsigned AccW  = RndW + 1;

  logic signed [ProdW-1:0] p_q;
  logic signed [ProdW-1:0] rnd;
  logic signed [RndW-1:0]  r_q;
  logic signed [AccW-1:0]  acc;
  q16_t                    sat;
  q16_t                    sum_q;

  always_comb begin
    // Round to nearest, ties toward plus infinity
    rnd = p_q + $signed(ProdW'(1) << (FracW - 1));
    acc = AccW'(force_i) + AccW'(r_q);
    // Clamp when the bits above the sign of a Q16.16 word disagree
    if (!acc[AccW-1] && (|acc[AccW-2:DataW-1])) begin
      sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (acc[AccW-1] && !(&acc[AccW-2:DataW-1])) begin
      sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      sat = acc[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= ProdW'(scale_i) * ProdW'(entry_i);
      r_q   <= rnd[ProdW-1:FracW];
      sum_q <= use_i ? sat : force_i;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/grid_force_lookup_add_core.sv =====
// grid_force_lookup_add_core: top level of the nearest grid point force lookup-add.
// Depends on gfl_pkg, gfl_axis, gfl_index, gfl_table, gfl_scale_add.
//
//   channel  direction  handshake                  payload
//   -------  ---------  -------------------------  ------------------------------
//   in       input      in_valid_i / in_ready_o    in_beat_i  (gfl_pkg::in_beat_t)
//   out      output     out_valid_o / out_ready_i  out_beat_o (gfl_pkg::out_beat_t)
//   cfg      input      cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One beat per cycle is sustained while the output does not stall. Stages: offset,
//   cell multiply, row/plane scale, index sum and range check, table access, scale
//   multiply, round, saturating add.
// A load beat writes the table at the same stage where apply beats read it, so
//   reads and writes keep input order; the single port serves one beat per advance.
// Reset zeroes valid bits and origins, sets cpl and scale to 1.0; table not cleared.
// Stalls: the whole pipe holds while a result waits unaccepted; nothing moves,
//   drops or repeats. Load beats ride the pipe to its end and are dropped at the
//   output register.
module grid_force_lookup_add_core #(
  parameter int unsigned GRID_X = 32,
  parameter int unsigned GRID_Y = 32,
  parameter int unsigned GRID_Z = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gfl_pkg::in_beat_t           in_beat_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output gfl_pkg::out_beat_t          out_beat_o,
  input  logic                        cfg_we_i,
  input  logic [gfl_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [gfl_pkg::DataW-1:0]   cfg_wdata_i
);
  import gfl_pkg::*;

  localparam int unsigned TableSize = table_cells(GRID_X, GRID_Y, GRID_Z);
  localparam int unsigned LastStg   = 7;   // stages ahead of the output register
  localparam int unsigned MemStg    = 4;   // stage whose beat accesses the table
  localparam logic [DataW-1:0] OneQ16 = DataW'(1) << (DataW / 2);

  // Side-band carried with each beat
  typedef struct packed {
    op_e  op;
    logic grp;
    vec_t frc;
  } side_t;

  typedef struct packed {
    logic [IdxOutW-1:0] index;
    vec_t               data;
  } entry_t;

  // Configuration
  q16_t             origin_x_q;
  q16_t             origin_y_q;
  q16_t             origin_z_q;
  logic [DataW-1:0] cpl_x_q;
  logic [DataW-1:0] cpl_y_q;
  logic [DataW-1:0] cpl_z_q;
  q16_t             scale_q;

  // Pipeline control and side-band
  logic               adv;
  logic [LastStg:1]   vld_q;
  side_t              side_q [1:LastStg];
  entry_t             ent_q  [1:MemStg];
  lookup_t            lk_q   [MemStg+1:LastStg];
  lookup_t            out_lk_q;
  logic               out_valid_q;

  // Datapath links
  cell_t              cell_x;
  cell_t              cell_y;
  cell_t              cell_z;
  lookup_t            lookup;
  logic [IdxOutW-1:0] tbl_addr;
  logic               tbl_load;
  vec_t               tbl_rdata;
  logic               use_tbl;
  q16_t               new_x;
  q16_t               new_y;
  q16_t               new_z;

  // Advance everything whenever the output register is free or being taken
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  //--------------------------------------------------------------------------
  // Configuration registers
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      cpl_x_q    <= OneQ16;
      cpl_y_q    <= OneQ16;
      cpl_z_q    <= OneQ16;
      scale_q    <= $signed(OneQ16);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ORIGIN_X:    origin_x_q <= $signed(cfg_wdata_i);
        REG_ORIGIN_Y:    origin_y_q <= $signed(cfg_wdata_i);
        REG_ORIGIN_Z:    origin_z_q <= $signed(cfg_wdata_i);
        REG_CPL_X:       cpl_x_q    <= cfg_wdata_i;
        REG_CPL_Y:       cpl_y_q    <= cfg_wdata_i;
        REG_CPL_Z:       cpl_z_q    <= cfg_wdata_i;
        REG_FORCE_SCALE: scale_q    <= $signed(cfg_wdata_i);
        default: ;  // ignore writes past the register list
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Valid bits and side-band shift
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[LastStg-1:1], in_valid_i};
      // Load beats end here; only apply beats become results
      out_valid_q <= vld_q[LastStg] && (side_q[LastStg].op == OP_APPLY);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[1].op    <= in_beat_i.operation;
      side_q[1].grp   <= in_beat_i.in_group;
      side_q[1].frc.x <= in_beat_i.force_x;
      side_q[1].frc.y <= in_beat_i.force_y;
      side_q[1].frc.z <= in_beat_i.force_z;
      for (int k = 2; k <= LastStg; k++) begin
        side_q[k] <= side_q[k-1];
      end

      ent_q[1].index  <= in_beat_i.entry_index;
      ent_q[1].data.x <= in_beat_i.entry_fx;
      ent_q[1].data.y <= in_beat_i.entry_fy;
      ent_q[1].data.z <= in_beat_i.entry_fz;
      for (int k = 2; k <= MemStg; k++) begin
        ent_q[k] <= ent_q[k-1];
      end

      lk_q[MemStg+1] <= lookup;
      for (int k = MemStg + 2; k <= LastStg; k++) begin
        lk_q[k] <= lk_q[k-1];
      end
      out_lk_q <= lk_q[LastStg];
    end
  end

  //--------------------------------------------------------------------------
  // Stages 1-2: per-axis cell
  //--------------------------------------------------------------------------
  gfl_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (adv),
    .pos_i    (in_beat_i.pos_x),
    .origin_i (origin_x_q),
    .cpl_i    (cpl_x_q),
    .cell_o   (cell_x)
  );

  gfl_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (adv),
    .pos_i    (in_beat_i.pos_y),
    .origin_i (origin_y_q),
    .cpl_i    (cpl_y_q),
    .cell_o   (cell_y)
  );

  gfl_axis u_axis_z (
    .clk_i    (clk_i),
    .en_i     (adv),
    .pos_i    (in_beat_i.pos_z),
    .origin_i (origin_z_q),
    .cpl_i    (cpl_z_q),
    .cell_o   (cell_z)
  );

  //--------------------------------------------------------------------------
  // Stages 3-4: linear index, x fastest, and range check
  //--------------------------------------------------------------------------
  gfl_index #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_index (
    .clk_i    (clk_i),
    .en_i     (adv),
    .cell_x_i (cell_x),
    .cell_y_i (cell_y),
    .cell_z_i (cell_z),
    .grp_i    (side_q[3].grp),
    .lookup_o (lookup)
  );

  //--------------------------------------------------------------------------
  // Stage 5: table access; a load writes, an apply reads
  //--------------------------------------------------------------------------
  assign tbl_load = vld_q[MemStg] && (side_q[MemStg].op == OP_LOAD);
  assign tbl_addr = (side_q[MemStg].op == OP_LOAD) ? ent_q[MemStg].index : lookup.slot;

  gfl_table #(
    .DEPTH (TableSize)
  ) u_table (
    .clk_i   (clk_i),
    .en_i    (adv),
    .load_i  (tbl_load),
    .addr_i  (tbl_addr),
    .wdata_i (ent_q[MemStg].data),
    .rdata_o (tbl_rdata)
  );

  //--------------------------------------------------------------------------
  // Stages 6-8: scale, round, saturating add; pass force through otherwise
  //--------------------------------------------------------------------------
  assign use_tbl = (lk_q[LastStg].status == ST_APPLIED);

  gfl_scale_add u_sa_x (
    .clk_i   (clk_i),
    .en_i    (adv),
    .scale_i (scale_q),
    .entry_i (tbl_rdata.x),
    .force_i (side_q[LastStg].frc.x),
    .use_i   (use_tbl),
    .sum_o   (new_x)
  );

  gfl_scale_add u_sa_y (
    .clk_i   (clk_i),
    .en_i    (adv),
    .scale_i (scale_q),
    .entry_i (tbl_rdata.y),
    .force_i (side_q[LastStg].frc.y),
    .use_i   (use_tbl),
    .sum_o   (new_y)
  );

  gfl_scale_add u_sa_z (
    .clk_i   (clk_i),
    .en_i    (adv),
    .scale_i (scale_q),
    .entry_i (tbl_rdata.z),
    .force_i (side_q[LastStg].frc.z),
    .use_i   (use_tbl),
    .sum_o   (new_z)
  );

  //--------------------------------------------------------------------------
  // Output beat
  //--------------------------------------------------------------------------
  assign out_valid_o            = out_valid_q;
  assign out_beat_o.new_force_x = new_x;
  assign out_beat_o.new_force_y = new_y;
  assign out_beat_o.new_force_z = new_z;
  assign out_beat_o.cell_index  = out_lk_q.slot;
  assign out_beat_o.status      = out_lk_q.status;

endmodule
